FILE: rtl/core/minmax_predicate_pruner_defines.svh
// ----------------------------------------------------------------------------
// minmax_predicate_pruner assertion macros
// shared assertion forms for the pruner: same-cycle and next-cycle implication
// ----------------------------------------------------------------------------
`ifndef MINMAX_PREDICATE_PRUNER_DEFINES_SVH
`define MINMAX_PREDICATE_PRUNER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MPP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MPP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// types and constants shared by the min/max predicate pruner modules
// ----------------------------------------------------------------------------
package mpp_pkg;

  localparam int MAX_LITERALS_DEF = 4;
  localparam int VALUE_WIDTH_DEF  = 64;

  // literal registers in the register map and width of the null mask
  localparam int NUM_LIT_REGS = 4;
  localparam int NULL_MASK_W  = 4;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    OP_IS_NULL   = 3'd0,
    OP_EQUALS    = 3'd1,
    OP_NS_EQUALS = 3'd2,
    OP_LESS      = 3'd3,
    OP_LESS_EQ   = 3'd4,
    OP_IN        = 3'd5,
    OP_BETWEEN   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    T_NO          = 3'd0,
    T_YES         = 3'd1,
    T_YES_NO      = 3'd2,
    T_NO_NULL     = 3'd3,
    T_YES_NULL    = 3'd4,
    T_YES_NO_NULL = 3'd5,
    T_IS_NULL     = 3'd6
  } truth_t;

  typedef enum logic [2:0] {
    REG_OPERATOR  = 3'd0,
    REG_LIT_COUNT = 3'd1,
    REG_NULL_MASK = 3'd2,
    REG_LIT0      = 3'd3,
    REG_LIT1      = 3'd4,
    REG_LIT2      = 3'd5,
    REG_LIT3      = 3'd6
  } reg_idx_t;

  // predicate control handed from the register file to the evaluator
  typedef struct packed {
    op_t                    op;
    logic [2:0]             lit_count;
    logic [NULL_MASK_W-1:0] null_mask;
  } pred_ctl_t;

endpackage

FILE: rtl/core/mpp_regs.sv
// ----------------------------------------------------------------------------
// mpp_regs
// apb register file holding the predicate operator, literal count, null mask
// and literal values
// ----------------------------------------------------------------------------
module mpp_regs #(
  parameter int MAX_LITERALS = mpp_pkg::MAX_LITERALS_DEF,
  parameter int VALUE_WIDTH  = mpp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [mpp_pkg::CFG_ADDR_W-1:0]             paddr,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]             pwdata,
  output logic [mpp_pkg::CFG_DATA_W-1:0]             prdata,
  output logic                                       pready,
  output mpp_pkg::pred_ctl_t                         ctl,
  output logic [MAX_LITERALS-1:0][VALUE_WIDTH-1:0]   lits
);
  import mpp_pkg::*;

  localparam int LIT_REGS = (MAX_LITERALS < NUM_LIT_REGS) ? MAX_LITERALS : NUM_LIT_REGS;

  pred_ctl_t                              ctl_r;
  logic [MAX_LITERALS-1:0][VALUE_WIDTH-1:0] lit_r;
  reg_idx_t                               idx;
  logic [2:0]                             lit_slot;
  logic                                   wr_en;
  logic                                   lit_wr;

  assign idx      = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign lit_slot = paddr[CFG_ADDR_W-1:3] - REG_LIT0;
  assign wr_en    = psel && penable && pwrite;
  assign lit_wr   = wr_en && (paddr[CFG_ADDR_W-1:3] >= REG_LIT0);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.op        <= OP_IS_NULL;
      ctl_r.lit_count <= '0;
      ctl_r.null_mask <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_OPERATOR:  ctl_r.op        <= op_t'(pwdata[2:0]);
        REG_LIT_COUNT: ctl_r.lit_count <= pwdata[2:0];
        REG_NULL_MASK: ctl_r.null_mask <= pwdata[NULL_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // literals beyond the register map stay at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= '0;
    end else begin
      for (int i = 0; i < LIT_REGS; i++) begin
        if (lit_wr && (lit_slot == 3'(i))) begin
          lit_r[i] <= pwdata[VALUE_WIDTH-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_OPERATOR:  prdata = CFG_DATA_W'(ctl_r.op);
      REG_LIT_COUNT: prdata = CFG_DATA_W'(ctl_r.lit_count);
      REG_NULL_MASK: prdata = CFG_DATA_W'(ctl_r.null_mask);
      default: begin
        for (int i = 0; i < LIT_REGS; i++) begin
          if (lit_slot == 3'(i)) begin
            prdata = CFG_DATA_W'($signed(lit_r[i]));
          end
        end
      end
    endcase
  end

  assign ctl  = ctl_r;
  assign lits = lit_r;

endmodule

FILE: rtl/core/mpp_eval.sv
// ----------------------------------------------------------------------------
// mpp_eval
// single-pass predicate evaluation: per-literal range compares, compaction of
// the non-null literal list and the truth decision
// ----------------------------------------------------------------------------
module mpp_eval #(
  parameter int MAX_LITERALS = mpp_pkg::MAX_LITERALS_DEF,
  parameter int VALUE_WIDTH  = mpp_pkg::VALUE_WIDTH_DEF
) (
  input  mpp_pkg::pred_ctl_t                       ctl,
  input  logic [MAX_LITERALS-1:0][VALUE_WIDTH-1:0] lits,
  input  logic [VALUE_WIDTH-1:0]                   stat_lo,
  input  logic [VALUE_WIDTH-1:0]                   stat_hi,
  input  logic                                     null_flag,
  input  logic                                     all_null,
  input  logic                                     present,
  output mpp_pkg::truth_t                          truth
);
  import mpp_pkg::*;

  typedef enum logic [2:0] {
    LOC_BEFORE,
    LOC_MIN,
    LOC_MIDDLE,
    LOC_MAX,
    LOC_AFTER
  } loc_t;

  localparam int MASK_EXT_W = MAX_LITERALS + NULL_MASK_W;

  function automatic loc_t locate(logic lt_lo, logic eq_lo, logic gt_hi, logic eq_hi);
    loc_t l;
    if (lt_lo)      l = LOC_BEFORE;
    else if (eq_lo) l = LOC_MIN;
    else if (gt_hi) l = LOC_AFTER;
    else if (eq_hi) l = LOC_MAX;
    else            l = LOC_MIDDLE;
    return l;
  endfunction

  function automatic truth_t pick(logic hn, truth_t plain, truth_t with_null);
    return hn ? with_null : plain;
  endfunction

  logic [MASK_EXT_W-1:0]   mask_ext;
  logic [MAX_LITERALS-1:0] lane_in_use;
  logic [MAX_LITERALS-1:0] lane_val;
  logic [MAX_LITERALS-1:0] lane_eq_lo;
  logic [MAX_LITERALS-1:0] lane_in_rng;
  loc_t                    lane_loc [MAX_LITERALS];
  loc_t                    loc0;
  loc_t                    loc1;
  logic [1:0]              n_sat;
  logic                    any_null_lit;
  logic                    same;
  truth_t                  fault;
  truth_t                  rule;

  assign mask_ext = MASK_EXT_W'(ctl.null_mask);
  assign same     = (stat_lo == stat_hi);
  assign fault    = pick(null_flag, T_YES_NO, T_YES_NO_NULL);

  // per-literal compares against the group bounds
  always_comb begin
    for (int i = 0; i < MAX_LITERALS; i++) begin
      logic lt_lo, eq_lo, gt_hi, eq_hi;
      lt_lo = $signed(lits[i]) < $signed(stat_lo);
      eq_lo = lits[i] == stat_lo;
      gt_hi = $signed(lits[i]) > $signed(stat_hi);
      eq_hi = lits[i] == stat_hi;
      lane_in_use[i] = ctl.lit_count > 3'(i);
      lane_val[i]    = lane_in_use[i] && !mask_ext[i];
      lane_eq_lo[i]  = eq_lo;
      lane_loc[i]    = locate(lt_lo, eq_lo, gt_hi, eq_hi);
      lane_in_rng[i] = !lt_lo && (eq_lo || !gt_hi);
    end
  end

  // first and second entries of the compacted value list
  always_comb begin
    n_sat        = 2'd0;
    loc0         = LOC_BEFORE;
    loc1         = LOC_BEFORE;
    any_null_lit = 1'b0;
    for (int i = 0; i < MAX_LITERALS; i++) begin
      if (lane_in_use[i] && mask_ext[i]) begin
        any_null_lit = 1'b1;
      end
      if (lane_val[i]) begin
        if (n_sat == 2'd0)      loc0 = lane_loc[i];
        else if (n_sat == 2'd1) loc1 = lane_loc[i];
        if (n_sat != 2'd2) n_sat = n_sat + 2'd1;
      end
    end
  end

  // min/max range rule
  always_comb begin
    rule = fault;
    unique case (ctl.op)
      OP_NS_EQUALS: begin
        if (n_sat == 2'd0)                          rule = fault;
        else if (loc0 inside {LOC_BEFORE, LOC_AFTER}) rule = T_NO;
        else                                        rule = T_YES_NO;
      end
      OP_EQUALS: begin
        if (n_sat == 2'd0)                          rule = fault;
        else if (same && (loc0 == LOC_MIN))         rule = pick(null_flag, T_YES, T_YES_NULL);
        else if (loc0 inside {LOC_BEFORE, LOC_AFTER}) rule = pick(null_flag, T_NO, T_NO_NULL);
        else                                        rule = fault;
      end
      OP_LESS: begin
        if (n_sat == 2'd0)                          rule = fault;
        else if (loc0 == LOC_AFTER)                 rule = pick(null_flag, T_YES, T_YES_NULL);
        else if (loc0 inside {LOC_BEFORE, LOC_MIN}) rule = pick(null_flag, T_NO, T_NO_NULL);
        else                                        rule = fault;
      end
      OP_LESS_EQ: begin
        if (n_sat == 2'd0) begin
          rule = fault;
        end else if ((loc0 inside {LOC_AFTER, LOC_MAX}) || ((loc0 == LOC_MIN) && same)) begin
          rule = pick(null_flag, T_YES, T_YES_NULL);
        end else if (loc0 == LOC_BEFORE) begin
          rule = pick(null_flag, T_NO, T_NO_NULL);
        end else begin
          rule = fault;
        end
      end
      OP_IN: begin
        // only one kind of hit applies per group, so list order does not matter
        if (same) begin
          rule = |(lane_val & lane_eq_lo) ? pick(null_flag, T_YES, T_YES_NULL)
                                          : pick(null_flag, T_NO, T_NO_NULL);
        end else begin
          rule = |(lane_val & lane_in_rng) ? fault : pick(null_flag, T_NO, T_NO_NULL);
        end
      end
      OP_BETWEEN: begin
        if (n_sat == 2'd0) begin
          rule = T_YES_NO;
        end else if (loc0 inside {LOC_BEFORE, LOC_MIN}) begin
          if (n_sat == 2'd1)                          rule = fault;
          else if (loc1 inside {LOC_AFTER, LOC_MAX})  rule = pick(null_flag, T_YES, T_YES_NULL);
          else if (loc1 == LOC_BEFORE)                rule = pick(null_flag, T_NO, T_NO_NULL);
          else                                        rule = fault;
        end else if (loc0 == LOC_AFTER) begin
          rule = pick(null_flag, T_NO, T_NO_NULL);
        end else begin
          rule = fault;
        end
      end
      default: rule = fault;
    endcase
  end

  // order of checks: missing literal, null test, all-null, null in IN list, range rule
  always_comb begin
    logic eq_like;
    eq_like = (ctl.op == OP_EQUALS) || (ctl.op == OP_NS_EQUALS);
    if (eq_like && (ctl.lit_count == 3'd0)) begin
      truth = fault;
    end else if ((ctl.op == OP_IS_NULL) || (eq_like && ctl.null_mask[0])) begin
      truth = all_null ? T_YES : pick(null_flag, T_NO, T_YES_NO);
    end else if (all_null) begin
      truth = T_IS_NULL;
    end else if ((ctl.op == OP_IN) && null_flag && any_null_lit) begin
      truth = T_YES_NO_NULL;
    end else if (present) begin
      truth = rule;
    end else begin
      truth = T_YES_NO_NULL;
    end
  end

endmodule

FILE: rtl/core/minmax_predicate_pruner.sv
// ----------------------------------------------------------------------------
// minmax_predicate_pruner
// decides from one row group's integer min/max statistics whether a configured
// predicate can match rows in that group
// ----------------------------------------------------------------------------
// One statistics item goes in and one truth code comes out per transfer. The
// block takes a new item every clock cycle while the output side does not
// stall. Each item passes through the input register, then through the
// comparator stage into the result register. Throughput is set by that single
// comparator stage, which compares every literal against both bounds in
// parallel. The output register frees the input side, so a waiting result never
// holds off the next transfer unless both registers are full. Configuration
// sits on an apb-style port with 64-bit data at byte address 8*i: operator,
// literal count, literal null mask, then four literals. Write it only while no
// transfer is in flight.
// ----------------------------------------------------------------------------
module minmax_predicate_pruner #(
  parameter int MAX_LITERALS = mpp_pkg::MAX_LITERALS_DEF,
  parameter int VALUE_WIDTH  = mpp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // statistics input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_stats_min,
  input  logic [63:0]                    in_stats_max,
  input  logic                           in_null_flag,
  input  logic [31:0]                    in_value_count,
  input  logic                           in_stats_present,
  // truth code output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_truth,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mpp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mpp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mpp_pkg::*;
  `include "minmax_predicate_pruner_defines.svh"

  pred_ctl_t                                ctl;
  logic [MAX_LITERALS-1:0][VALUE_WIDTH-1:0] lits;

  // input register (stage one)
  logic                   s1_valid_r, s1_valid_nxt;
  logic [VALUE_WIDTH-1:0] s1_lo_r;
  logic [VALUE_WIDTH-1:0] s1_hi_r;
  logic                   s1_hn_r;
  logic                   s1_all_null_r;
  logic                   s1_present_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  truth_t                 out_truth_r;
  truth_t                 eval_truth;

  logic                   out_free;
  logic                   in_xfer;

  mpp_regs #(
    .MAX_LITERALS (MAX_LITERALS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl),
    .lits    (lits)
  );

  // result register can take a new code when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // input stage holds only when its item cannot move on
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !out_free);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // statistics payload; only the low value bits take part in the compares
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_lo_r       <= in_stats_min[VALUE_WIDTH-1:0];
      s1_hi_r       <= in_stats_max[VALUE_WIDTH-1:0];
      s1_hn_r       <= in_null_flag;
      s1_all_null_r <= in_null_flag && (in_value_count == 32'd0);
      s1_present_r  <= in_stats_present;
    end
  end

  mpp_eval #(
    .MAX_LITERALS (MAX_LITERALS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_eval (
    .ctl       (ctl),
    .lits      (lits),
    .stat_lo   (s1_lo_r),
    .stat_hi   (s1_hi_r),
    .null_flag (s1_hn_r),
    .all_null  (s1_all_null_r),
    .present   (s1_present_r),
    .truth     (eval_truth)
  );

  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_truth_r <= eval_truth;
    end
  end

  assign out_valid = out_valid_r;
  assign out_truth = out_truth_r;

  // an accepted item always lands in the input stage
  `MPP_ASSERT_NXT(a_in_lands, clk, rst_n, in_xfer, s1_valid_r, "item lost at input stage")
  // a staged item moving on always shows up as a result
  `MPP_ASSERT_NXT(a_s1_moves, clk, rst_n, s1_valid_r && out_free, out_valid_r, "staged item lost")
  // input only stalls when both stages are occupied
  `MPP_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r, "early stall")
  // a delivered code is one of the seven truth values
  `MPP_ASSERT_IMP(a_truth_rng, clk, rst_n, out_valid_r, out_truth_r <= T_IS_NULL, "bad truth")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min/max predicate pruner: programs predicates
// over the apb-style port, streams row group statistics with random idling on
// both channels and compares every truth code with a local prediction
// ----------------------------------------------------------------------------
module tb_top;
  import mpp_pkg::*;

  localparam int MAX_LITS = MAX_LITERALS_DEF;
  // operator code with no predicate behind it, the range rule gives the fault code
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // two register stages in the block, plus margin
  localparam int SETTLE_CYCLES = 8;

  // where a literal falls relative to the group's bounds
  typedef enum logic [2:0] {
    LOC_BEFORE,
    LOC_MIN,
    LOC_MIDDLE,
    LOC_MAX,
    LOC_AFTER
  } loc_t;

  typedef struct {
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic               null_flag;
    logic [31:0]        value_count;
    logic               present;
  } stats_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [63:0] in_stats_min     = '0;
  logic [63:0] in_stats_max     = '0;
  logic        in_null_flag     = 1'b0;
  logic [31:0] in_value_count   = '0;
  logic        in_stats_present = 1'b0;
  logic        out_stall        = 1'b0;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr  = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [2:0]            out_truth;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the predicate registers, reset values to start with
  logic [2:0]         pred_op        = OP_IS_NULL;
  logic [2:0]         pred_count     = '0;
  logic [3:0]         pred_null_mask = '0;
  logic signed [63:0] pred_lit [MAX_LITS] = '{default: '0};

  truth_t pending_truths [$];
  int     err_count    = 0;
  bit     idle_enable  = 1'b0;
  int     stall_left   = 0;
  int     quiet_cycles = 0;

  minmax_predicate_pruner i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stats_min     (in_stats_min),
    .in_stats_max     (in_stats_max),
    .in_null_flag     (in_null_flag),
    .in_value_count   (in_value_count),
    .in_stats_present (in_stats_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_truth        (out_truth),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // order of checks mirrors the block: signed compare against min first, then max
  function automatic loc_t locate(logic signed [63:0] p, logic signed [63:0] lo,
                                  logic signed [63:0] hi);
    if (p < lo) return LOC_BEFORE;
    if (p == lo) return LOC_MIN;
    if (p > hi) return LOC_AFTER;
    if (p == hi) return LOC_MAX;
    return LOC_MIDDLE;
  endfunction

  function automatic truth_t pick(logic hn, truth_t plain, truth_t with_null);
    return hn ? with_null : plain;
  endfunction

  function automatic truth_t predict_truth(stats_t s);
    logic signed [63:0] vals [MAX_LITS];
    int                 cnt;
    int                 n;
    int                 i;
    logic               any_null_lit;
    logic               all_null;
    logic               same;
    logic               hn;
    truth_t             fault;
    truth_t             r;
    loc_t               loc;
    loc_t               loc2;
    hn           = s.null_flag;
    fault        = pick(hn, T_YES_NO, T_YES_NO_NULL);
    all_null     = hn && (s.value_count == '0);
    same         = (s.lo == s.hi);
    cnt          = (pred_count < MAX_LITS) ? int'(pred_count) : MAX_LITS;
    n            = 0;
    any_null_lit = 1'b0;
    vals         = '{default: '0};
    // null literals drop out, the rest are packed to the front
    for (i = 0; i < cnt; i++) begin
      if (pred_null_mask[i]) begin
        any_null_lit = 1'b1;
      end else begin
        vals[n] = pred_lit[i];
        n++;
      end
    end

    // equality with no literal at all is a fault, ahead of the all-null check
    if ((pred_op == OP_EQUALS || pred_op == OP_NS_EQUALS) && cnt == 0) return fault;
    // is-null, or equality against a null first literal
    if (pred_op == OP_IS_NULL ||
        ((pred_op == OP_EQUALS || pred_op == OP_NS_EQUALS) && pred_null_mask[0]))
      return all_null ? T_YES : pick(hn, T_NO, T_YES_NO);
    if (all_null) return T_IS_NULL;

    // missing statistics leave the answer fully open
    r = T_YES_NO_NULL;
    if (s.present) begin
      loc = locate(vals[0], s.lo, s.hi);
      case (pred_op)
        OP_NS_EQUALS: begin
          if (n == 0) r = fault;
          else r = (loc == LOC_BEFORE || loc == LOC_AFTER) ? T_NO : T_YES_NO;
        end
        OP_EQUALS: begin
          if (n == 0) r = fault;
          else if (same && loc == LOC_MIN) r = pick(hn, T_YES, T_YES_NULL);
          else if (loc == LOC_BEFORE || loc == LOC_AFTER) r = pick(hn, T_NO, T_NO_NULL);
          else r = fault;
        end
        OP_LESS: begin
          if (n == 0) r = fault;
          else if (loc == LOC_AFTER) r = pick(hn, T_YES, T_YES_NULL);
          else if (loc == LOC_BEFORE || loc == LOC_MIN) r = pick(hn, T_NO, T_NO_NULL);
          else r = fault;
        end
        OP_LESS_EQ: begin
          if (n == 0) r = fault;
          else if (loc == LOC_AFTER || loc == LOC_MAX || (loc == LOC_MIN && same))
            r = pick(hn, T_YES, T_YES_NULL);
          else if (loc == LOC_BEFORE) r = pick(hn, T_NO, T_NO_NULL);
          else r = fault;
        end
        OP_IN: begin
          r = pick(hn, T_NO, T_NO_NULL);
          for (i = 0; i < n; i++) begin
            loc2 = locate(vals[i], s.lo, s.hi);
            if (same) begin
              if (loc2 == LOC_MIN) begin
                r = pick(hn, T_YES, T_YES_NULL);
                break;
              end
            end else if (loc2 == LOC_MIN || loc2 == LOC_MIDDLE || loc2 == LOC_MAX) begin
              r = fault;
              break;
            end
          end
        end
        OP_BETWEEN: begin
          if (n == 0) begin
            r = T_YES_NO;
          end else if (loc == LOC_BEFORE || loc == LOC_MIN) begin
            // lower bound clears the group, the upper bound decides
            if (n < 2) begin
              r = fault;
            end else begin
              loc2 = locate(vals[1], s.lo, s.hi);
              if (loc2 == LOC_AFTER || loc2 == LOC_MAX) r = pick(hn, T_YES, T_YES_NULL);
              else if (loc2 == LOC_BEFORE) r = pick(hn, T_NO, T_NO_NULL);
              else r = fault;
            end
          end else if (loc == LOC_AFTER) begin
            r = pick(hn, T_NO, T_NO_NULL);
          end else begin
            r = fault;
          end
        end
        default: r = fault;
      endcase
    end

    // a null member of the IN list can match the group's nulls
    if (pred_op == OP_IN && hn && any_null_lit) r = T_YES_NO_NULL;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly close to a base so literals land on and around the bounds
  function automatic logic signed [63:0] pick_value(logic signed [63:0] base);
    case ($urandom_range(0, 9))
      7:       return {$urandom, $urandom};
      8:       return VAL_MIN;
      9:       return VAL_MAX;
      default: return base + 64'($urandom_range(0, 8)) - 64'sd4;
    endcase
  endfunction

  function automatic stats_t make_stats(logic signed [63:0] lo, logic signed [63:0] hi,
                                        logic hn, logic [31:0] vc, logic present);
    stats_t s;
    s.lo          = lo;
    s.hi          = hi;
    s.null_flag   = hn;
    s.value_count = vc;
    s.present     = present;
    return s;
  endfunction

  function automatic stats_t rand_stats(logic signed [63:0] base);
    stats_t             s;
    logic signed [63:0] t;
    s.lo = pick_value(base);
    s.hi = pick_value(base);
    // mostly well-ordered groups, some with min above max
    if (s.lo > s.hi && $urandom_range(0, 5) != 0) begin
      t    = s.lo;
      s.lo = s.hi;
      s.hi = t;
    end
    if ($urandom_range(0, 7) == 0) s.hi = s.lo;
    s.null_flag = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       s.value_count = '0;
      1:       s.value_count = $urandom_range(1, 16);
      default: s.value_count = $urandom;
    endcase
    s.present = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // writes every register; only called with nothing in flight
  task automatic set_predicate(input logic [2:0] op, input logic [2:0] count,
                               input logic [3:0] mask,
                               input logic signed [63:0] l0, input logic signed [63:0] l1,
                               input logic signed [63:0] l2, input logic signed [63:0] l3);
    apb_write(REG_OPERATOR, 64'(op));
    apb_write(REG_LIT_COUNT, 64'(count));
    apb_write(REG_NULL_MASK, 64'(mask));
    apb_write(REG_LIT0, l0);
    apb_write(REG_LIT1, l1);
    apb_write(REG_LIT2, l2);
    apb_write(REG_LIT3, l3);
    psel           <= 1'b0;
    penable        <= 1'b0;
    pred_op        = op;
    pred_count     = count;
    pred_null_mask = mask;
    pred_lit[0]    = l0;
    pred_lit[1]    = l1;
    pred_lit[2]    = l2;
    pred_lit[3]    = l3;
  endtask

  task automatic randomise_predicate(output logic signed [63:0] base);
    logic [2:0] count;
    logic [3:0] mask;
    case ($urandom_range(0, 5))
      0:       base = '0;
      1:       base = VAL_MIN + 64'sd2;
      2:       base = VAL_MAX - 64'sd2;
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 9))
      0:       count = '0;
      9:       count = 3'($urandom_range(5, 7));
      default: count = 3'($urandom_range(1, 4));
    endcase
    mask = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'b0000;
    set_predicate(3'($urandom_range(0, 7)), count, mask, pick_value(base), pick_value(base),
                  pick_value(base), pick_value(base));
  endtask

  // one statistics transfer; valid stays high into the next item unless a gap is drawn
  task automatic send_stats(input stats_t s);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_stats_min     <= s.lo;
    in_stats_max     <= s.hi;
    in_null_flag     <= s.null_flag;
    in_value_count   <= s.value_count;
    in_stats_present <= s.present;
    do @(posedge clk); while (in_stall);
    pending_truths.push_back(predict_truth(s));
  endtask

  // every item yields a truth code, so an empty queue means the block is idle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_truths.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers untouched: is-null against the reset state
  task automatic test_reset_state;
    idle_enable = 1'b1;
    send_stats(make_stats(64'sd0, 64'sd0, 1'b1, 32'd0, 1'b1));
    send_stats(make_stats(64'sd1, 64'sd9, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_stats(make_stats(VAL_MIN, VAL_MAX, 1'b0, 32'd7, 1'b0));
    drain();
  endtask

  // each operator with its edge cases
  task automatic test_operators;
    idle_enable = 1'b1;
    // equality without any literal
    set_predicate(OP_EQUALS, 3'd0, 4'b0000, 64'sd5, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b1, 32'd3, 1'b1));
    drain();
    // equality against a null literal
    set_predicate(OP_EQUALS, 3'd1, 4'b0001, 64'sd5, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b0, 32'd3, 1'b1));
    drain();
    set_predicate(OP_EQUALS, 3'd1, 4'b0000, 64'sd5, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd5, 64'sd5, 1'b0, 32'd1, 1'b1));
    send_stats(make_stats(64'sd0, 64'sd10, 1'b1, 32'd4, 1'b1));
    send_stats(make_stats(64'sd6, 64'sd10, 1'b0, 32'd4, 1'b1));
    send_stats(make_stats(64'sd0, 64'sd10, 1'b1, 32'd0, 1'b1));
    send_stats(make_stats(64'sd0, 64'sd10, 1'b0, 32'd4, 1'b0));
    // min above max is taken as given
    send_stats(make_stats(64'sd10, 64'sd0, 1'b0, 32'd4, 1'b1));
    drain();
    set_predicate(OP_NS_EQUALS, 3'd1, 4'b0000, VAL_MIN, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(VAL_MIN, VAL_MAX, 1'b0, 32'hFFFF_FFFF, 1'b1));
    send_stats(make_stats(-64'sd1, VAL_MAX, 1'b1, 32'd2, 1'b1));
    drain();
    // less-than whose only literal is null
    set_predicate(OP_LESS, 3'd1, 4'b0001, 64'sd3, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b0, 32'd2, 1'b1));
    drain();
    set_predicate(OP_LESS_EQ, 3'd1, 4'b0000, VAL_MAX, 64'sd0, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, VAL_MAX, 1'b1, 32'd2, 1'b1));
    drain();
    // IN list with a null member
    set_predicate(OP_IN, 3'd4, 4'b0100, 64'sd1, 64'sd2, 64'sd4, 64'sd7);
    send_stats(make_stats(64'sd7, 64'sd7, 1'b0, 32'd1, 1'b1));
    send_stats(make_stats(64'sd3, 64'sd5, 1'b1, 32'd2, 1'b1));
    send_stats(make_stats(64'sd3, 64'sd6, 1'b0, 32'd2, 1'b1));
    drain();
    // IN with nothing in the list
    set_predicate(OP_IN, 3'd0, 4'b0000, 64'sd1, 64'sd2, 64'sd4, 64'sd7);
    send_stats(make_stats(64'sd3, 64'sd6, 1'b1, 32'd2, 1'b1));
    drain();
    // between with only the lower bound
    set_predicate(OP_BETWEEN, 3'd1, 4'b0000, -64'sd5, 64'sd20, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b0, 32'd2, 1'b1));
    drain();
    set_predicate(OP_BETWEEN, 3'd2, 4'b0000, -64'sd5, 64'sd20, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b0, 32'd2, 1'b1));
    send_stats(make_stats(64'sd0, 64'sd30, 1'b1, 32'd2, 1'b1));
    drain();
    set_predicate(OP_BETWEEN, 3'd0, 4'b0000, -64'sd5, 64'sd20, 64'sd0, 64'sd0);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b1, 32'd2, 1'b1));
    drain();
    // unused operator code, count beyond the literal registers, every literal null
    set_predicate(OP_UNUSED, 3'd7, 4'b1111, VAL_MAX, VAL_MIN, -64'sd1, 64'sd1);
    send_stats(make_stats(64'sd0, 64'sd10, 1'b1, 32'd2, 1'b1));
    drain();
  endtask

  // random predicates, each followed by a burst of related statistics
  task automatic test_random_predicates;
    logic signed [63:0] base;
    repeat (24) begin
      randomise_predicate(base);
      idle_enable = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(30, 50)) send_stats(rand_stats(base));
      drain();
    end
  endtask

  // full rate on both channels to close the run
  task automatic test_streaming;
    logic signed [63:0] base;
    idle_enable = 1'b0;
    repeat (3) begin
      randomise_predicate(base);
      repeat (40) send_stats(rand_stats(base));
      drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_operators();
    test_random_predicates();
    test_streaming();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // back-pressure in random bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n || !idle_enable) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // each truth transfer against the oldest prediction
  always @(posedge clk) begin
    truth_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_truths.size() == 0) begin
        err_count++;
        $error("truth: expected nothing, actual %0d", out_truth);
      end else begin
        want = pending_truths.pop_front();
        if (out_truth !== want) begin
          err_count++;
          $error("truth: expected %0d (%s), actual %0d", want, want.name(), out_truth);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

FILE: minmax_predicate_pruner.f
+incdir+rtl/core
rtl/core/mpp_pkg.sv
rtl/core/mpp_regs.sv
rtl/core/mpp_eval.sv
rtl/core/minmax_predicate_pruner.sv
bench/tb_top.sv
